// ===== hw/rtl/aging_frame_fifo_drop_oldest_macros.svh =====
// Assertion macros for the aging frame queue.
// Used by the top level; no other dependencies.
`ifndef AGING_FRAME_FIFO_DROP_OLDEST_MACROS_SVH
`define AGING_FRAME_FIFO_DROP_OLDEST_MACROS_SVH
`ifndef SYNTHESIS
`define AFQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define AFQ_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("assertion failed");
`else
`define AFQ_ASSERT(label, clk, rst_n, prop)
`define AFQ_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

// ===== hw/rtl/afq_pkg.sv =====
// Package for the aging frame queue: sizes, codes and helpers.
// No dependencies.
package afq_pkg;
  localparam int QueueFrames = 8;
  localparam int FrameBytes  = 64;
  localparam int SlotW   = $clog2(QueueFrames);
  localparam int ByteW   = $clog2(FrameBytes);
  localparam int LenW    = $clog2(FrameBytes + 1);
  localparam int FillW   = $clog2(QueueFrames + 1);
  localparam int AddrW   = SlotW + ByteW;

  localparam logic [1:0] FuncPush  = 2'd0;
  localparam logic [1:0] FuncPop   = 2'd1;
  localparam logic [1:0] FuncQuery = 2'd2;

  localparam logic [2:0] StQueued  = 3'd0;
  localparam logic [2:0] StDropped = 3'd1;
  localparam logic [2:0] StInvalid = 3'd2;
  localparam logic [2:0] StData    = 3'd3;
  localparam logic [2:0] StEmpty   = 3'd4;
  localparam logic [2:0] StFresh   = 3'd5;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

// ===== hw/rtl/aging_frame_fifo_drop_oldest.sv =====
// Aging frame queue with drop-oldest overflow: top level.
// Uses afq_pkg, afq_ram and aging_frame_fifo_drop_oldest_macros.svh.
//
// Usage: raise start with func_i and the request fields while busy is
// low; the request is taken at that edge. Each result is on the result ports
// with res_valid_o high for exactly one cycle; out_last_o marks the final
// result of a request. The receiver cannot stall.
// Sequence from the accepting cycle: a non-last push byte and a rejected
// frame go to S_DONE. A last push byte that is queued copies the
// staged frame into the frame memory, one byte a cycle through the staging
// RAM read port, then writes its stamp and length. A pop skips each stale
// head frame (stamp memory read), then reports an empty queue or emits each
// popped byte through a frame memory read. A query reads each queued stamp
// in turn. Reset clears all control state and counters; the frame, stamp,
// length and staging memories hold undefined data that is never read before
// written. max_age is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle, as the block itself does not enforce this.
module aging_frame_fifo_drop_oldest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        frame_ok_i,
  input  logic [31:0] now_time_i,
  output logic        res_valid_o,
  output logic [2:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [6:0]  frame_length_o,
  output logic [3:0]  fill_level_o,
  output logic        fresh_present_o,
  output logic [31:0] invalid_count_o,
  output logic [31:0] overflow_count_o,
  output logic [31:0] stale_count_o,
  output logic [31:0] queued_count_o,
  output logic [3:0]  peak_fill_o
);
  import afq_pkg::*;
  `include "aging_frame_fifo_drop_oldest_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_COPY, S_COPY_END, S_POP_RD, S_POP_CHK, S_POP_LEN, S_POP_OUT,
    S_POP_OUT_W, S_Q_RD, S_Q_CHK, S_DONE
  } state_e;

  state_e             state_q;
  logic [31:0]        max_age_q, now_q;
  logic [LenW-1:0]    stg_len_q;
  logic               too_long_q;
  logic [SlotW-1:0]   head_q, slot_q, k_slot_q;
  logic [FillW-1:0]   fill_q, peak_q, k_q;
  logic [31:0]        cnt_inv_q, cnt_ovf_q, cnt_stale_q, cnt_que_q;
  logic [LenW-1:0]    idx_q, len_q;
  logic [SlotW-1:0]   tail_q;
  logic               fwd_q;
  logic [7:0]         fwd_byte_q;

  // memories
  logic               st_we, fs_we, meta_we;
  logic [ByteW-1:0]   st_waddr, st_raddr;
  logic [7:0]         st_rdata, fs_rdata, fs_wdata;
  logic [AddrW-1:0]   fs_waddr, fs_raddr;
  logic [SlotW-1:0]   meta_raddr;
  logic [31:0]        stamp_rdata;
  logic [LenW-1:0]    len_rdata;

  afq_ram #(.Width(8), .Depth(FrameBytes)) u_stage (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(data_byte_i),
    .raddr_i(st_raddr), .rdata_o(st_rdata));
  afq_ram #(.Width(8), .Depth(QueueFrames * FrameBytes)) u_frames (
    .clk_i, .we_i(fs_we), .waddr_i(fs_waddr), .wdata_i(fs_wdata),
    .raddr_i(fs_raddr), .rdata_o(fs_rdata));
  afq_ram #(.Width(32), .Depth(QueueFrames)) u_stamps (
    .clk_i, .we_i(meta_we), .waddr_i(tail_q), .wdata_i(now_q),
    .raddr_i(meta_raddr), .rdata_o(stamp_rdata));
  afq_ram #(.Width(LenW), .Depth(QueueFrames)) u_lens (
    .clk_i, .we_i(meta_we), .waddr_i(tail_q), .wdata_i(stg_len_q),
    .raddr_i(meta_raddr), .rdata_o(len_rdata));

  logic accept, stale;
  logic [31:0] age;
  logic [LenW-1:0] copy_idx_d;
  assign accept = start && !busy;
  assign age    = now_q - stamp_rdata;
  assign stale  = (max_age_q != 32'd0) && (age > max_age_q);

  // staging write on push accept; read address walks the copy
  assign st_we    = accept && func_i == FuncPush && stg_len_q < LenW'(FrameBytes);
  assign st_waddr = stg_len_q[ByteW-1:0];
  assign copy_idx_d = (state_q == S_COPY) ? idx_q + LenW'(1) : '0;
  assign st_raddr = copy_idx_d[ByteW-1:0];
  // frame write trails the registered staging read; a one-byte frame was
  // staged at the same edge as its read, so forward that byte
  assign fs_we    = state_q == S_COPY;
  assign fs_wdata = fwd_q ? fwd_byte_q : st_rdata;
  assign fs_waddr = {tail_q, idx_q[ByteW-1:0]};
  assign fs_raddr = {slot_q, idx_q[ByteW-1:0]};
  assign meta_we  = state_q == S_COPY_END;
  assign meta_raddr = (state_q == S_Q_RD || state_q == S_Q_CHK) ? k_slot_q : head_q;

  // sequencer, registered outputs and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; busy <= 1'b0; max_age_q <= '0; now_q <= '0;
      stg_len_q <= '0; too_long_q <= 1'b0; head_q <= '0; fill_q <= '0;
      peak_q <= '0; cnt_inv_q <= '0; cnt_ovf_q <= '0; cnt_stale_q <= '0;
      cnt_que_q <= '0; idx_q <= '0; len_q <= '0; tail_q <= '0; slot_q <= '0;
      k_q <= '0; k_slot_q <= '0; res_valid_o <= 1'b0; status_o <= '0;
      out_byte_o <= '0; out_last_o <= 1'b0; frame_length_o <= '0;
      fresh_present_o <= 1'b0; fwd_q <= 1'b0; fwd_byte_q <= '0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        max_age_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            now_q <= now_time_i;
            busy  <= 1'b1;
            state_q <= S_DONE;
            case (func_i)
              FuncPush: begin
                if (stg_len_q < LenW'(FrameBytes)) begin
                  stg_len_q <= stg_len_q + LenW'(1);
                end else begin
                  too_long_q <= 1'b1;
                end
                if (last_byte_i) begin
                  if (!frame_ok_i || too_long_q || stg_len_q >= LenW'(FrameBytes)) begin
                    cnt_inv_q <= sat_inc(cnt_inv_q);
                    stg_len_q <= '0; too_long_q <= 1'b0;
                    res_valid_o <= 1'b1; status_o <= StInvalid;
                    out_byte_o <= '0; out_last_o <= 1'b1;
                    frame_length_o <= '0; fresh_present_o <= 1'b0;
                  end else begin
                    status_o <= StQueued;
                    if (fill_q >= FillW'(QueueFrames)) begin
                      head_q <= head_q + SlotW'(1);
                      tail_q <= head_q;
                      fill_q <= fill_q - FillW'(1);
                      cnt_ovf_q <= sat_inc(cnt_ovf_q);
                      status_o <= StDropped;
                    end else begin
                      tail_q <= SlotW'(head_q + fill_q[SlotW-1:0]);
                    end
                    fwd_q <= (stg_len_q == '0);
                    fwd_byte_q <= data_byte_i;
                    idx_q <= '0;
                    state_q <= S_COPY;
                  end
                end
              end
              FuncPop: state_q <= S_POP_RD;
              FuncQuery: begin
                k_q <= '0; k_slot_q <= head_q; state_q <= S_Q_RD;
              end
              default: ;
            endcase
          end
        end
        // move staged bytes into the tail slot
        S_COPY: begin
          idx_q <= idx_q + LenW'(1);
          if (idx_q + LenW'(1) >= stg_len_q) state_q <= S_COPY_END;
        end
        S_COPY_END: begin
          fill_q <= fill_q + FillW'(1);
          if (fill_q + FillW'(1) > peak_q) peak_q <= fill_q + FillW'(1);
          cnt_que_q <= sat_inc(cnt_que_q);
          stg_len_q <= '0; too_long_q <= 1'b0;
          res_valid_o <= 1'b1; out_byte_o <= '0; out_last_o <= 1'b1;
          frame_length_o <= '0; fresh_present_o <= 1'b0;
          state_q <= S_DONE;
        end
        // stamp of head is being read
        S_POP_RD: begin
          if (fill_q == '0) begin
            res_valid_o <= 1'b1; status_o <= StEmpty; out_byte_o <= '0;
            out_last_o <= 1'b1; frame_length_o <= '0; fresh_present_o <= 1'b0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_POP_CHK;
          end
        end
        // drop stale head or start emitting
        S_POP_CHK: begin
          if (stale) begin
            head_q <= head_q + SlotW'(1);
            fill_q <= fill_q - FillW'(1);
            cnt_stale_q <= sat_inc(cnt_stale_q);
            state_q <= S_POP_RD;
          end else begin
            len_q <= (len_rdata > LenW'(FrameBytes)) ? LenW'(FrameBytes) : len_rdata;
            slot_q <= head_q;
            head_q <= head_q + SlotW'(1);
            fill_q <= fill_q - FillW'(1);
            idx_q <= '0;
            state_q <= S_POP_LEN;
          end
        end
        S_POP_LEN: begin
          if (len_q == '0) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_POP_OUT_W;
          end
        end
        // issue read of byte idx; S_POP_OUT registers it onto the output
        S_POP_OUT_W: begin
          idx_q <= idx_q + LenW'(1);
          state_q <= S_POP_OUT;
        end
        S_POP_OUT: begin
          res_valid_o <= 1'b1; status_o <= StData; out_byte_o <= fs_rdata;
          out_last_o <= (idx_q == len_q); frame_length_o <= 7'(len_q);
          fresh_present_o <= 1'b0;
          state_q <= (idx_q == len_q) ? S_DONE : S_POP_OUT_W;
        end
        // walk queued stamps looking for a fresh one
        S_Q_RD: begin
          if (k_q == fill_q) begin
            res_valid_o <= 1'b1; status_o <= StFresh; out_byte_o <= '0;
            out_last_o <= 1'b1; frame_length_o <= '0; fresh_present_o <= 1'b0;
            state_q <= S_DONE;
          end else begin
            state_q <= S_Q_CHK;
          end
        end
        S_Q_CHK: begin
          if (!stale) begin
            res_valid_o <= 1'b1; status_o <= StFresh; out_byte_o <= '0;
            out_last_o <= 1'b1; frame_length_o <= '0; fresh_present_o <= 1'b1;
            state_q <= S_DONE;
          end else begin
            k_q <= k_q + FillW'(1);
            k_slot_q <= k_slot_q + SlotW'(1);
            state_q <= S_Q_RD;
          end
        end
        S_DONE: begin
          busy <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign fill_level_o     = 4'(fill_q);
  assign peak_fill_o      = 4'(peak_q);
  assign invalid_count_o  = cnt_inv_q;
  assign overflow_count_o = cnt_ovf_q;
  assign stale_count_o    = cnt_stale_q;
  assign queued_count_o   = cnt_que_q;

  `AFQ_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > FillW'(QueueFrames))
  `AFQ_ASSERT_NEVER(a_peak_ge_fill, clk_i, rst_ni, peak_q < fill_q)
  `AFQ_ASSERT(a_res_when_busy, clk_i, rst_ni, res_valid_o |-> $past(busy) || busy)
  `AFQ_ASSERT_NEVER(a_stage_bound, clk_i, rst_ni, stg_len_q > LenW'(FrameBytes))
endmodule

// ===== hw/rtl/afq_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module afq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
